[rtl/prt_pkg.sv]
// ---------------------------------------------------------------------------
// prt_pkg
// Shared types, constants and the arctangent table for the point rotator.
// ---------------------------------------------------------------------------
package prt_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ANG_W        = 34;
    localparam int TRIG_W       = 34;

    localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = TRIG_W'(652032874);
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1073741824);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] angle;
    } t_in;

    typedef struct packed {
        logic signed [31:0] rotated_x;
        logic signed [31:0] rotated_y;
        logic signed [31:0] rotated_z;
        logic               saturated;
    } t_out;

    // point, the two rotated center coordinates and their differences
    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] cu;
        logic signed [31:0] cv;
        logic signed [32:0] du;
        logic signed [32:0] dv;
    } t_geo;

    typedef struct packed {
        t_geo                    geo;
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic                    flip;
    } t_cst;

    // atan(2^-i) in q2.30, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0: v = ANG_W'(843314857);
            1: v = ANG_W'(497837829);
            2: v = ANG_W'(263043837);
            3: v = ANG_W'(133525159);
            4: v = ANG_W'(67021687);
            5: v = ANG_W'(33543516);
            6: v = ANG_W'(16775851);
            7: v = ANG_W'(8388437);
            8: v = ANG_W'(4194283);
            9: v = ANG_W'(2097149);
            default: begin
                if (idx <= 30) begin
                    v = ANG_W'(1) << (30 - idx);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

[rtl/point_rotate_about_axis.sv]
// ---------------------------------------------------------------------------
// point_rotate_about_axis
// Rotates a q16.16 point about an axis-parallel line through a center.
// ---------------------------------------------------------------------------
// Takes one point per clock and delivers one result per clock while the
// consumer keeps up. Between input and output lie two front-end stages, one
// stage per cordic iteration, five back-end stages and the output register.
// A skid register behind the output lets the pipeline take one more
// transaction after the consumer stalls; input ready drops only once it is
// full. Axis code three passes the point through unchanged.
module point_rotate_about_axis
    import prt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic w_en;
    logic w_free;
    logic w_rv_vld;
    t_cst w_rv_data;
    logic w_cd_vld;
    t_cst w_cd_data;
    logic w_pvld;
    t_out w_pdata;

    logic r_out_vld;
    t_out r_out;
    logic r_skd_vld;
    t_out r_skd;

    assign w_en   = !r_skd_vld;
    assign w_free = !r_out_vld || i_out_ready;

    prt_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_rv_vld),
        .o_data  (w_rv_data)
    );

    prt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rv_vld),
        .i_data  (w_rv_data),
        .o_valid (w_cd_vld),
        .o_data  (w_cd_data)
    );

    prt_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cd_vld),
        .i_data  (w_cd_data),
        .o_valid (w_pvld),
        .o_data  (w_pdata)
    );

    // output register and skid buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            if (w_free) begin
                r_out_vld <= 1'b1;
                r_skd_vld <= 1'b0;
            end
        end else if (w_free) begin
            r_out_vld <= w_pvld;
        end else if (w_pvld) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_vld) begin
            if (w_free) begin
                r_out <= r_skd;
            end
        end else if (w_free) begin
            r_out <= w_pdata;
        end else if (w_pvld) begin
            r_skd <= w_pdata;
        end
    end

    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[rtl/prt_reduce.sv]
// ---------------------------------------------------------------------------
// prt_reduce
// Two-stage front end: center differences, axis selection, angle reduction
// to [-pi, pi] and folding into [-pi/2, pi/2] for the cordic.
// ---------------------------------------------------------------------------
module prt_reduce
    import prt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_valid,
    output t_cst o_data
);

    logic signed [32:0] w_ang;
    logic signed [32:0] n_ang;
    t_geo               n_geo;
    logic signed [34:0] w_z;
    logic signed [34:0] w_zf;
    t_cst               n_cst;

    logic               r_vld1;
    logic               r_vld2;
    logic signed [32:0] r_ang1;
    t_geo               r_geo1;
    t_cst               r_cst2;

    // stage 1
    always_comb begin
        w_ang = 33'(i_data.angle);
        if (w_ang > PI_Q28) begin
            n_ang = w_ang - TWO_PI_Q28;
        end else if (w_ang < -PI_Q28) begin
            n_ang = w_ang + TWO_PI_Q28;
        end else begin
            n_ang = w_ang;
        end

        n_geo.axis = i_data.action;
        n_geo.px   = i_data.point_x;
        n_geo.py   = i_data.point_y;
        n_geo.pz   = i_data.point_z;
        case (i_data.action)
            AXIS_X: begin
                n_geo.cu = i_data.center_y;
                n_geo.cv = i_data.center_z;
                n_geo.du = 33'(i_data.point_y) - 33'(i_data.center_y);
                n_geo.dv = 33'(i_data.point_z) - 33'(i_data.center_z);
            end
            AXIS_Y: begin
                n_geo.cu = i_data.center_z;
                n_geo.cv = i_data.center_x;
                n_geo.du = 33'(i_data.point_z) - 33'(i_data.center_z);
                n_geo.dv = 33'(i_data.point_x) - 33'(i_data.center_x);
            end
            default: begin
                n_geo.cu = i_data.center_x;
                n_geo.cv = i_data.center_y;
                n_geo.du = 33'(i_data.point_x) - 33'(i_data.center_x);
                n_geo.dv = 33'(i_data.point_y) - 33'(i_data.center_y);
            end
        endcase
    end

    // stage 2: to q2.30 and fold
    always_comb begin
        w_z        = 35'(r_ang1) <<< 2;
        n_cst.flip = 1'b0;
        if (w_z > HALF_PI_Q30) begin
            w_zf       = w_z - PI_Q30;
            n_cst.flip = 1'b1;
        end else if (w_z < -HALF_PI_Q30) begin
            w_zf       = w_z + PI_Q30;
            n_cst.flip = 1'b1;
        end else begin
            w_zf = w_z;
        end
        n_cst.z   = ANG_W'(w_zf);
        n_cst.x   = GAIN_Q30;
        n_cst.y   = '0;
        n_cst.geo = r_geo1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang1 <= n_ang;
            r_geo1 <= n_geo;
            r_cst2 <= n_cst;
        end
    end

    assign o_valid = r_vld2;
    assign o_data  = r_cst2;

endmodule

[rtl/prt_cordic.sv]
// ---------------------------------------------------------------------------
// prt_cordic
// Rotation-mode cordic, one registered stage per iteration.
// ---------------------------------------------------------------------------
module prt_cordic
    import prt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_cst i_data,
    output logic o_valid,
    output t_cst o_data
);

    t_cst                     w_src [CORDIC_STEPS];
    t_cst                     n_st  [CORDIC_STEPS];
    logic signed [TRIG_W-1:0] w_xs  [CORDIC_STEPS];
    logic signed [TRIG_W-1:0] w_ys  [CORDIC_STEPS];
    t_cst                     r_st  [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0]  r_vld;

    assign w_src[0] = i_data;
    for (genvar g = 1; g < CORDIC_STEPS; g++) begin : g_src
        assign w_src[g] = r_st[g-1];
    end

    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            w_xs[k] = $signed(w_src[k].x) >>> k;
            w_ys[k] = $signed(w_src[k].y) >>> k;
            n_st[k] = w_src[k];
            if (!w_src[k].z[ANG_W-1]) begin
                n_st[k].x = w_src[k].x - w_ys[k];
                n_st[k].y = w_src[k].y + w_xs[k];
                n_st[k].z = w_src[k].z - atan_q30(k);
            end else begin
                n_st[k].x = w_src[k].x + w_ys[k];
                n_st[k].y = w_src[k].y - w_xs[k];
                n_st[k].z = w_src[k].z + atan_q30(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[CORDIC_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid = r_vld[CORDIC_STEPS-1];
    assign o_data  = r_st[CORDIC_STEPS-1];

endmodule

[rtl/prt_combine.sv]
// ---------------------------------------------------------------------------
// prt_combine
// Back end: sign fix and clamp of sine and cosine, four products, rounding,
// recombination with the center, saturation and axis remap.
// ---------------------------------------------------------------------------
module prt_combine
    import prt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_cst i_data,
    output logic o_valid,
    output t_out o_data
);

    localparam logic signed [64:0] RND     = 65'sd536870912;
    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

    logic signed [TRIG_W-1:0] w_xf;
    logic signed [TRIG_W-1:0] w_yf;
    logic signed [31:0]       n_cos;
    logic signed [31:0]       n_sin;
    logic signed [64:0]       n_uc;
    logic signed [64:0]       n_vs;
    logic signed [64:0]       n_us;
    logic signed [64:0]       n_vc;
    logic signed [33:0]       n_ruc;
    logic signed [33:0]       n_rvs;
    logic signed [33:0]       n_rus;
    logic signed [33:0]       n_rvc;
    logic signed [35:0]       n_su;
    logic signed [35:0]       n_sv;
    logic signed [31:0]       w_cu;
    logic signed [31:0]       w_cv;
    logic                     w_clip;
    t_out                     n_out;

    logic [4:0]               r_vld;
    t_geo                     r_t_geo;
    logic signed [31:0]       r_t_cos;
    logic signed [31:0]       r_t_sin;
    t_geo                     r_m_geo;
    logic signed [64:0]       r_m_uc;
    logic signed [64:0]       r_m_vs;
    logic signed [64:0]       r_m_us;
    logic signed [64:0]       r_m_vc;
    t_geo                     r_r_geo;
    logic signed [33:0]       r_r_uc;
    logic signed [33:0]       r_r_vs;
    logic signed [33:0]       r_r_us;
    logic signed [33:0]       r_r_vc;
    t_geo                     r_c_geo;
    logic signed [35:0]       r_c_su;
    logic signed [35:0]       r_c_sv;
    t_out                     r_out;

    // sign fix and clamp to [-1, 1]
    always_comb begin
        w_xf = i_data.flip ? -i_data.x : i_data.x;
        w_yf = i_data.flip ? -i_data.y : i_data.y;
        if (w_xf > TRIG_ONE) begin
            n_cos = 32'(TRIG_ONE);
        end else if (w_xf < -TRIG_ONE) begin
            n_cos = 32'(-TRIG_ONE);
        end else begin
            n_cos = 32'(w_xf);
        end
        if (w_yf > TRIG_ONE) begin
            n_sin = 32'(TRIG_ONE);
        end else if (w_yf < -TRIG_ONE) begin
            n_sin = 32'(-TRIG_ONE);
        end else begin
            n_sin = 32'(w_yf);
        end
    end

    // products
    always_comb begin
        n_uc = $signed(r_t_geo.du) * r_t_cos;
        n_vs = $signed(r_t_geo.dv) * r_t_sin;
        n_us = $signed(r_t_geo.du) * r_t_sin;
        n_vc = $signed(r_t_geo.dv) * r_t_cos;
    end

    // round to nearest, ties up
    always_comb begin
        n_ruc = 34'((r_m_uc + RND) >>> 30);
        n_rvs = 34'((r_m_vs + RND) >>> 30);
        n_rus = 34'((r_m_us + RND) >>> 30);
        n_rvc = 34'((r_m_vc + RND) >>> 30);
    end

    // recombine and add center back
    always_comb begin
        n_su = 36'(r_r_uc) - 36'(r_r_vs) + 36'($signed(r_r_geo.cu));
        n_sv = 36'(r_r_us) + 36'(r_r_vc) + 36'($signed(r_r_geo.cv));
    end

    // saturate and map back to x, y, z
    always_comb begin
        w_clip = 1'b0;
        if (r_c_su > SAT_MAX) begin
            w_cu   = 32'(SAT_MAX);
            w_clip = 1'b1;
        end else if (r_c_su < SAT_MIN) begin
            w_cu   = 32'(SAT_MIN);
            w_clip = 1'b1;
        end else begin
            w_cu = 32'(r_c_su);
        end
        if (r_c_sv > SAT_MAX) begin
            w_cv   = 32'(SAT_MAX);
            w_clip = 1'b1;
        end else if (r_c_sv < SAT_MIN) begin
            w_cv   = 32'(SAT_MIN);
            w_clip = 1'b1;
        end else begin
            w_cv = 32'(r_c_sv);
        end

        n_out.saturated = w_clip;
        case (r_c_geo.axis)
            AXIS_X: begin
                n_out.rotated_x = r_c_geo.px;
                n_out.rotated_y = w_cu;
                n_out.rotated_z = w_cv;
            end
            AXIS_Y: begin
                n_out.rotated_x = w_cv;
                n_out.rotated_y = r_c_geo.py;
                n_out.rotated_z = w_cu;
            end
            AXIS_Z: begin
                n_out.rotated_x = w_cu;
                n_out.rotated_y = w_cv;
                n_out.rotated_z = r_c_geo.pz;
            end
            default: begin
                n_out.rotated_x = r_c_geo.px;
                n_out.rotated_y = r_c_geo.py;
                n_out.rotated_z = r_c_geo.pz;
                n_out.saturated = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t_geo <= i_data.geo;
            r_t_cos <= n_cos;
            r_t_sin <= n_sin;
            r_m_geo <= r_t_geo;
            r_m_uc  <= n_uc;
            r_m_vs  <= n_vs;
            r_m_us  <= n_us;
            r_m_vc  <= n_vc;
            r_r_geo <= r_m_geo;
            r_r_uc  <= n_ruc;
            r_r_vs  <= n_rvs;
            r_r_us  <= n_rus;
            r_r_vc  <= n_rvc;
            r_c_geo <= r_r_geo;
            r_c_su  <= n_su;
            r_c_sv  <= n_sv;
            r_out   <= n_out;
        end
    end

    assign o_valid = r_vld[4];
    assign o_data  = r_out;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks point_rotate_about_axis transaction by transaction.
// ---------------------------------------------------------------------------
// A short table of directed points (axis extremes, angle wrap and quadrant
// boundaries, clipping, the no-rotation code) is followed by random points.
// Every accepted input gets its expected rotated point, from the table or a
// bit-exact fixed-point predictor, queued; each output transaction is compared
// field by field with the oldest queued point. Both handshakes idle and
// stall at random, with bursts in which that side does not hold off.
// ---------------------------------------------------------------------------
module testbench;
    import prt_pkg::*;

    localparam int         HALF_PERIOD   = 6;
    localparam int         RESET_CYCLES  = 5;
    localparam int         RANDOM_POINTS = 1000;
    localparam int         SETTLE_CYCLES = 48;
    localparam int         STALL_LIMIT   = 2000;
    localparam logic [1:0] AXIS_NONE     = 2'd3;

    localparam longint ANG_PI       = 64'sd843314857;
    localparam longint ANG_TWO_PI   = 64'sd1686629713;
    localparam longint Q30_HALF_PI  = 64'sd1686629713;
    localparam longint Q30_PI       = 64'sd3373259426;
    localparam longint CORDIC_START = 64'sd652032874;
    localparam longint UNIT_Q30     = 64'sd1073741824;
    localparam longint COORD_MAX    = 64'sd2147483647;
    localparam longint COORD_MIN    = -64'sd2147483648;

    typedef struct {
        t_in  stim;
        bit   known;
        t_out want;
    } t_row;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_data   = '0;
    logic in_ready;
    logic out_valid;
    t_out out_data;

    t_out rotated_q[$];
    t_row rows[$];
    int   mismatches      = 0;
    int   results_checked = 0;
    int   points_sent     = 0;
    int   clipped_seen    = 0;
    int   idle_cycles     = 0;
    int   axis_count[4]   = '{0, 0, 0, 0};
    bit   burst_in        = 1'b0;
    bit   burst_out       = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    point_rotate_about_axis u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // atan(2^-i) in q2.30
    function automatic longint atan_step(input int i);
        case (i)
            0: return 843314857;
            1: return 497837829;
            2: return 263043837;
            3: return 133525159;
            4: return 67021687;
            5: return 33543516;
            6: return 16775851;
            7: return 8388437;
            8: return 4194283;
            9: return 2097149;
            default: return (i <= 30) ? (longint'(1) << (30 - i)) : 64'sd0;
        endcase
    endfunction

    function automatic void sin_cos_of(input longint ang, output longint s,
                                       output longint c);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        x    = CORDIC_START;
        y    = 0;
        flip = 1'b0;
        if (ang > ANG_PI) begin
            ang -= ANG_TWO_PI;
        end else if (ang < -ANG_PI) begin
            ang += ANG_TWO_PI;
        end
        z = ang * 4;
        if (z > Q30_HALF_PI) begin
            z -= Q30_PI;
            flip = 1'b1;
        end else if (z < -Q30_HALF_PI) begin
            z += Q30_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_step(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x > UNIT_Q30) ? UNIT_Q30 : (x < -UNIT_Q30) ? -UNIT_Q30 : x;
        s = (y > UNIT_Q30) ? UNIT_Q30 : (y < -UNIT_Q30) ? -UNIT_Q30 : y;
    endfunction

    // product rounded to nearest, ties up, back to q16.16
    function automatic longint scale_q30(input longint d, input longint t);
        return (d * t + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic t_out rotate_point(input t_in p);
        longint pt[3];
        longint ctr[3];
        longint dif[3];
        longint res[3];
        longint s;
        longint c;
        int     u;
        int     v;
        bit     clip;
        t_out   o;
        pt[0]  = $signed(p.point_x);
        pt[1]  = $signed(p.point_y);
        pt[2]  = $signed(p.point_z);
        ctr[0] = $signed(p.center_x);
        ctr[1] = $signed(p.center_y);
        ctr[2] = $signed(p.center_z);
        clip   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            dif[k] = pt[k] - ctr[k];
            res[k] = pt[k];
        end
        if (p.action != AXIS_NONE) begin
            // x -> (y, z), y -> (z, x), z -> (x, y)
            u = (int'(p.action) + 1) % 3;
            v = (int'(p.action) + 2) % 3;
            sin_cos_of($signed(p.angle), s, c);
            res[u] = scale_q30(dif[u], c) - scale_q30(dif[v], s) + ctr[u];
            res[v] = scale_q30(dif[u], s) + scale_q30(dif[v], c) + ctr[v];
            for (int k = 0; k < 3; k++) begin
                if (res[k] > COORD_MAX) begin
                    res[k] = COORD_MAX;
                    clip   = 1'b1;
                end else if (res[k] < COORD_MIN) begin
                    res[k] = COORD_MIN;
                    clip   = 1'b1;
                end
            end
        end
        o.rotated_x = res[0][31:0];
        o.rotated_y = res[1][31:0];
        o.rotated_z = res[2][31:0];
        o.saturated = clip;
        return o;
    endfunction

    function automatic t_in make_point(input logic [1:0] axis,
                                       input logic [31:0] px, py, pz,
                                       input logic [31:0] cx, cy, cz,
                                       input logic [31:0] ang);
        t_in p;
        p.action   = axis;
        p.point_x  = px;
        p.point_y  = py;
        p.point_z  = pz;
        p.center_x = cx;
        p.center_y = cy;
        p.center_z = cz;
        p.angle    = ang;
        return p;
    endfunction

    task automatic add_row(input t_in stim, input bit known, input t_out want);
        t_row r;
        r.stim  = stim;
        r.known = known;
        r.want  = want;
        rows.push_back(r);
    endtask

    // kind 0: any value, 1 and 3: near the origin, 2: large magnitude
    function automatic logic [31:0] rand_coord(input int kind);
        logic [31:0] val;
        val = $urandom;
        case (kind)
            1, 3: val = $urandom_range(0, 2097152) - 32'd1048576;
            2: val[30:27] = {4{~val[31]}};
            default: ;
        endcase
        return val;
    endfunction

    function automatic t_in rand_point();
        t_in p;
        int  sel;
        int  kind;
        sel  = $urandom_range(0, 7);
        kind = $urandom_range(0, 3);
        p.action = (sel == 7) ? AXIS_NONE : (sel < 3) ? AXIS_X :
                   (sel < 5) ? AXIS_Y : AXIS_Z;
        p.point_x  = rand_coord(kind);
        p.point_y  = rand_coord(kind);
        p.point_z  = rand_coord(kind);
        p.center_x = rand_coord(kind);
        p.center_y = rand_coord(kind);
        p.center_z = rand_coord(kind);
        if ($urandom_range(0, 15) == 0) begin
            p.center_x = p.point_x;
            p.center_y = p.point_y;
            p.center_z = p.point_z;
        end
        if ($urandom_range(0, 1) == 0) begin
            p.angle = $urandom;
        end else begin
            p.angle = $urandom_range(0, 32'(2 * ANG_PI)) - 32'(ANG_PI);
        end
        return p;
    endfunction

    task automatic send_point(input t_in p, input t_out want);
        int gap;
        gap = burst_in ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge clk); while (in_ready !== 1'b1);
        rotated_q.push_back(want);
        points_sent++;
        axis_count[p.action]++;
        @(negedge clk);
        if ($urandom_range(0, 31) == 0) begin
            burst_in = !burst_in;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : check_result
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (rotated_q.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h",
                         $time, out_data);
                mismatches++;
            end else begin
                want = rotated_q.pop_front();
                results_checked++;
                if (want.saturated) begin
                    clipped_seen++;
                end
                compare_field("rotated_x", want.rotated_x, out_data.rotated_x);
                compare_field("rotated_y", want.rotated_y, out_data.rotated_y);
                compare_field("rotated_z", want.rotated_z, out_data.rotated_z);
                compare_field("saturated", 32'(want.saturated),
                              32'(out_data.saturated));
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // result side back-pressure
    initial begin : drive_out_ready
        int stall;
        @(negedge clk);
        forever begin
            stall = burst_out ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && out_valid === 1'b1));
            @(negedge clk);
            if ($urandom_range(0, 31) == 0) begin
                burst_out = !burst_out;
            end
        end
    end

    initial begin : stimulus
        t_in p;
        // point unchanged when no rotation or when the point is the center
        p = make_point(AXIS_NONE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
        add_row(p, 1'b1, '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0});
        p = make_point(AXIS_NONE, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        add_row(p, 1'b1, '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0});
        p = make_point(AXIS_X, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h00000000);
        add_row(p, 1'b1, '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0});
        p = make_point(AXIS_Y, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'd843314857);
        add_row(p, 1'b1, '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0});
        p = make_point(AXIS_Z, 32'h12345678, 32'hedcba987, 32'h00010000,
                       32'h12345678, 32'hedcba987, 32'h00010000, 32'h80000000);
        add_row(p, 1'b1, '{32'h12345678, 32'hedcba987, 32'h00010000, 1'b0});
        // zero angle and quarter turns on every axis
        p = make_point(AXIS_X, 32'h00010000, 32'h00020000, 32'h00030000,
                       32'h0, 32'h0, 32'h0, 32'h0);
        add_row(p, 1'b0, '0);
        p.action = AXIS_Y;
        add_row(p, 1'b0, '0);
        p.action = AXIS_Z;
        add_row(p, 1'b0, '0);
        p.angle = 32'd421657428;
        add_row(p, 1'b0, '0);
        p.action = AXIS_X;
        add_row(p, 1'b0, '0);
        p.action = AXIS_Y;
        add_row(p, 1'b0, '0);
        // angle wrap at plus and minus pi, quadrant fold past pi/2
        p = make_point(AXIS_Z, 32'hfff4c000, 32'h00051234, 32'h00200000,
                       32'h00008000, 32'hffff0000, 32'h0, 32'd843314857);
        add_row(p, 1'b0, '0);
        p.angle = 32'd843314858;
        add_row(p, 1'b0, '0);
        p.angle = -32'sd843314858;
        add_row(p, 1'b0, '0);
        p.angle = -32'sd843314857;
        add_row(p, 1'b0, '0);
        p.action = AXIS_Y;
        p.angle  = 32'd421657429;
        add_row(p, 1'b0, '0);
        p.action = AXIS_X;
        p.angle  = -32'sd421657429;
        add_row(p, 1'b0, '0);
        p.angle = 32'h7fffffff;
        add_row(p, 1'b0, '0);
        p.action = AXIS_Y;
        p.angle  = 32'h80000000;
        add_row(p, 1'b0, '0);
        // clipping low and high
        p = make_point(AXIS_Z, 32'h7fffffff, 32'h0, 32'h0,
                       32'h80000000, 32'h0, 32'h0, 32'd843314857);
        add_row(p, 1'b0, '0);
        p = make_point(AXIS_Z, 32'h80000000, 32'h0, 32'h0,
                       32'h7fffffff, 32'h0, 32'h0, 32'd843314857);
        add_row(p, 1'b0, '0);
        p = make_point(AXIS_X, 32'h0, 32'h7fffffff, 32'h7fffffff,
                       32'h0, 32'h80000000, 32'h7fffffff, 32'd421657428);
        add_row(p, 1'b0, '0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_point(rows[i].stim,
                       rows[i].known ? rows[i].want : rotate_point(rows[i].stim));
        end
        for (int n = 0; n < RANDOM_POINTS; n++) begin
            p = rand_point();
            send_point(p, rotate_point(p));
        end
        in_valid <= 1'b0;

        while (rotated_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d points sent (x %0d, y %0d, z %0d, no rotation %0d)",
                 points_sent, axis_count[0], axis_count[1], axis_count[2],
                 axis_count[3]);
        $display("%0d results checked, %0d clipped, %0d mismatches",
                 results_checked, clipped_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
